// ----- src/ntcb_pkg.sv -----
`timescale 1ns / 1ps

package ntcb_pkg;

    localparam int ADC_BITS      = 12;
    localparam int CHANNEL_COUNT = 5;

    localparam int CODE_W    = 12;
    localparam int CHAN_W    = 3;
    localparam int TEMP_W    = 16;
    localparam int FAULT_W   = 2;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam int REF_W  = 13;
    localparam int RNOM_W = 24;
    localparam int BETA_W = 14;
    localparam int T2_W   = 16;
    localparam int MASK_W = 5;

    localparam int VN_W    = 24;                // code * 3300
    localparam int NUM1_W  = 36;                // scale * v * 256
    localparam int DEN1_W  = REF_W + ADC_BITS;  // ref * 2^ADC_BITS - v
    localparam int RT_W    = 24;
    localparam int P_W     = 5;
    localparam int MANT_W  = 31;                // Q1.30
    localparam int FRAC_W  = 24;
    localparam int LOG_W   = P_W + FRAC_W;
    localparam int BK_W    = 21;                // 100 * B
    localparam int BT_W    = BK_W + T2_W;       // 100 * B * T2
    localparam int KT_W    = BK_W + FRAC_W;     // 100 * B * 2^24, also ln * T2
    localparam int DEN2_W  = KT_W + 2;          // signed denominator
    localparam int D2_W    = DEN2_W - 1;        // positive denominator
    localparam int N2_W    = BT_W + FRAC_W;     // numerator plus half denominator
    localparam int Q2_W    = 17;

    localparam int LOG_STEPS  = 24;
    localparam int DIV1_STEPS = RT_W;
    localparam int DIV2_STEPS = Q2_W;

    localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((1 << ADC_BITS) - 1);
    localparam int FULL_SCALE_MV = 3300;
    localparam int WIDE_SCALE    = 10;
    localparam int ZERO_C_CENTIK = 27315;
    localparam int TEMP_MAX      = 32767;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [CFG_IDX_W-1:0] CFG_REF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RNOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_T2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 3'd4;

    localparam logic [FAULT_W-1:0] FAULT_OK   = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_HIGH = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_ZERO = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [FAULT_W-1:0] fault;
        logic               sat;
        logic [DEN1_W-1:0]  den;
        logic [DEN1_W-1:0]  r;
        logic [RT_W-1:0]    lo;
        logic [RT_W-1:0]    q;
    } div1_t;

    typedef struct packed {
        logic [P_W-1:0]    p;
        logic [MANT_W-1:0] m;
        logic [FRAC_W-1:0] frac;
    } lg_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [FAULT_W-1:0] fault;
        lg_t                lg;
    } lgc_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [FAULT_W-1:0] fault;
        logic               pos;
        logic               sat;
        logic [D2_W-1:0]    den;
        logic [D2_W-1:0]    r;
        logic [Q2_W-1:0]    lo;
        logic [Q2_W-1:0]    q;
    } div2_t;

    // one restoring step, quotient bit into q
    function automatic div1_t div1_step(div1_t s);
        div1_t           o;
        logic [DEN1_W:0] rs;
        logic            ge;
        o  = s;
        rs = {s.r, s.lo[RT_W-1]};
        ge = rs >= {1'b0, s.den};
        o.r  = ge ? DEN1_W'(rs - {1'b0, s.den}) : rs[DEN1_W-1:0];
        o.q  = {s.q[RT_W-2:0], ge};
        o.lo = {s.lo[RT_W-2:0], 1'b0};
        return o;
    endfunction

    function automatic div2_t div2_step(div2_t s);
        div2_t         o;
        logic [D2_W:0] rs;
        logic          ge;
        o  = s;
        rs = {s.r, s.lo[Q2_W-1]};
        ge = rs >= {1'b0, s.den};
        o.r  = ge ? D2_W'(rs - {1'b0, s.den}) : rs[D2_W-1:0];
        o.q  = {s.q[Q2_W-2:0], ge};
        o.lo = {s.lo[Q2_W-2:0], 1'b0};
        return o;
    endfunction

    // square the mantissa, renormalize, emit one fraction bit
    function automatic lg_t lg_step(lg_t s, int step);
        lg_t                 o;
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        o  = s;
        sq = (2*MANT_W)'(s.m) * (2*MANT_W)'(s.m);
        t  = sq[2*MANT_W-1:MANT_W-1];
        if (t[MANT_W])
        begin
            o.m    = t[MANT_W:1];
            o.frac = s.frac | (FRAC_W'(1) << (FRAC_W - 1 - step));
        end
        else
        begin
            o.m = t[MANT_W-1:0];
        end
        return o;
    endfunction

    function automatic logic [P_W-1:0] msb_index(logic [RT_W-1:0] x);
        logic [P_W-1:0] p;
        p = '0;
        for (int j = 0; j < RT_W; j++)
        begin
            if (x[j])
                p = P_W'(j);
        end
        return p;
    endfunction

    function automatic logic [MANT_W-1:0] normalize(logic [RT_W-1:0] x, logic [P_W-1:0] p);
        return MANT_W'(x) << (P_W'(MANT_W - 1) - p);
    endfunction

endpackage

// ----- src/ntc_beta_thermistor_converter.sv -----
`timescale 1ns / 1ps

// Channel   Signals                                         Dir  Handshake
// command   start, adc_code, sensor_channel                 in   start && !busy
// result    done, result_channel, temperature_centi,        out  done, one cycle
//           sensor_fault
// config    cfg_write, cfg_index, cfg_data                  in   cfg_write
//
// One word per clock. Most of the pipeline lies in the serial chains: 24 steps
// of the resistance divider, 24 squaring steps of the log2 unit and 17 steps of
// the temperature divider, one stage each.
// busy stays low; the pipeline never holds since results cannot be stalled.
// rst_n clears valid bits and loads the register defaults; datapath regs have no reset.
// The nominal resistance log runs in a free pipeline off the config registers,
// which is ahead of any word that follows a write.

module ntc_beta_thermistor_converter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ntcb_pkg::CODE_W-1:0]           adc_code,
    input  logic [ntcb_pkg::CHAN_W-1:0]           sensor_channel,
    output logic                                  done,
    output logic [ntcb_pkg::CHAN_W-1:0]           result_channel,
    output logic signed [ntcb_pkg::TEMP_W-1:0]    temperature_centi,
    output logic [ntcb_pkg::FAULT_W-1:0]          sensor_fault,
    input  logic                                  cfg_write,
    input  logic [ntcb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ntcb_pkg::CFG_W-1:0]            cfg_data
);

    // ---------------- configuration registers ----------------
    logic [ntcb_pkg::REF_W-1:0]  ref_reg;
    logic [ntcb_pkg::RNOM_W-1:0] rnom_reg;
    logic [ntcb_pkg::BETA_W-1:0] beta_reg;
    logic [ntcb_pkg::T2_W-1:0]   t2_reg;
    logic [ntcb_pkg::MASK_W-1:0] mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg  <= ntcb_pkg::REF_W'(3000);
            rnom_reg <= ntcb_pkg::RNOM_W'(2560);
            beta_reg <= ntcb_pkg::BETA_W'(3950);
            t2_reg   <= ntcb_pkg::T2_W'(29815);
            mask_reg <= ntcb_pkg::MASK_W'(22);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ntcb_pkg::CFG_REF:  ref_reg  <= cfg_data[ntcb_pkg::REF_W-1:0];
                ntcb_pkg::CFG_RNOM: rnom_reg <= cfg_data[ntcb_pkg::RNOM_W-1:0];
                ntcb_pkg::CFG_BETA: beta_reg <= cfg_data[ntcb_pkg::BETA_W-1:0];
                ntcb_pkg::CFG_T2:   t2_reg   <= cfg_data[ntcb_pkg::T2_W-1:0];
                ntcb_pkg::CFG_MASK: mask_reg <= cfg_data[ntcb_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- config-derived constants (free running) ----------------
    // 100*B and 100*B*T2; the 2^24 factors are appended as zero bits
    logic [ntcb_pkg::BK_W-1:0] bk_reg;
    logic [ntcb_pkg::BT_W-1:0] bt_reg;

    always_ff @(posedge clk)
    begin
        bk_reg <= ntcb_pkg::BK_W'(beta_reg) * ntcb_pkg::BK_W'(100);
        bt_reg <= ntcb_pkg::BT_W'(bk_reg) * ntcb_pkg::BT_W'(t2_reg);
    end

    // log2 of the nominal resistance, same steps as the item path
    logic [ntcb_pkg::RT_W-1:0] rn_x_next;
    logic [ntcb_pkg::RT_W-1:0] rn_x_reg;
    logic [ntcb_pkg::P_W-1:0]  rn_p_reg;
    ntcb_pkg::lg_t             rn_lg_reg  [0:ntcb_pkg::LOG_STEPS];
    ntcb_pkg::lg_t             rn_lg_next [0:ntcb_pkg::LOG_STEPS];

    assign rn_x_next = (rnom_reg == '0) ? ntcb_pkg::RT_W'(1) : rnom_reg;

    always_comb
    begin
        rn_lg_next[0].p    = rn_p_reg;
        rn_lg_next[0].m    = ntcb_pkg::normalize(rn_x_reg, rn_p_reg);
        rn_lg_next[0].frac = '0;
        for (int k = 1; k <= ntcb_pkg::LOG_STEPS; k++)
            rn_lg_next[k] = ntcb_pkg::lg_step(rn_lg_reg[k-1], k - 1);
    end

    always_ff @(posedge clk)
    begin
        rn_x_reg <= rn_x_next;
        rn_p_reg <= ntcb_pkg::msb_index(rn_x_next);
        for (int k = 0; k <= ntcb_pkg::LOG_STEPS; k++)
            rn_lg_reg[k] <= rn_lg_next[k];
    end

    // ---------------- stage A: fault check, divider operands ----------------
    logic [ntcb_pkg::CODE_W-1:0]  code;
    logic [ntcb_pkg::VN_W-1:0]    vnum;
    logic [ntcb_pkg::DEN1_W-1:0]  refnum;
    logic [7:0]                   mask_ext;
    logic                         wide;
    logic [ntcb_pkg::FAULT_W-1:0] a_fault_next;
    logic [ntcb_pkg::NUM1_W-1:0]  a_num_next;

    logic                         a_vld_reg;
    logic [ntcb_pkg::CHAN_W-1:0]  a_chan_reg;
    logic [ntcb_pkg::FAULT_W-1:0] a_fault_reg;
    logic [ntcb_pkg::NUM1_W-1:0]  a_num_reg;
    logic [ntcb_pkg::DEN1_W-1:0]  a_den_reg;

    always_comb
    begin
        code     = adc_code & ntcb_pkg::CODE_MASK;
        vnum     = ntcb_pkg::VN_W'(code) * ntcb_pkg::VN_W'(ntcb_pkg::FULL_SCALE_MV);
        refnum   = {ref_reg, ntcb_pkg::ADC_BITS'(0)};
        mask_ext = 8'(mask_reg);
        wide     = (32'(sensor_channel) < ntcb_pkg::MASK_W)
                && (32'(sensor_channel) < ntcb_pkg::CHANNEL_COUNT)
                && mask_ext[sensor_channel];
        if (code == '0)
            a_fault_next = ntcb_pkg::FAULT_ZERO;
        else if (32'(vnum) >= 32'(refnum))
            a_fault_next = ntcb_pkg::FAULT_HIGH;
        else
            a_fault_next = ntcb_pkg::FAULT_OK;
        if (wide)
            a_num_next = ntcb_pkg::NUM1_W'(vnum) * ntcb_pkg::NUM1_W'(ntcb_pkg::WIDE_SCALE * 256);
        else
            a_num_next = ntcb_pkg::NUM1_W'(vnum) << 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a_chan_reg  <= sensor_channel;
        a_fault_reg <= a_fault_next;
        a_num_reg   <= a_num_next;
        a_den_reg   <= refnum - ntcb_pkg::DEN1_W'(vnum);
    end

    // ---------------- resistance divider, one quotient bit a stage ----------------
    // quotient limited to 24 bits; larger ratios flag saturation up front
    ntcb_pkg::div1_t                 dv_reg  [0:ntcb_pkg::DIV1_STEPS];
    ntcb_pkg::div1_t                 dv_next [0:ntcb_pkg::DIV1_STEPS];
    logic [ntcb_pkg::DIV1_STEPS:0]   dv_vld_reg;

    always_comb
    begin
        dv_next[0].chan  = a_chan_reg;
        dv_next[0].fault = a_fault_reg;
        dv_next[0].den   = a_den_reg;
        dv_next[0].sat   = ntcb_pkg::DEN1_W'(a_num_reg[ntcb_pkg::NUM1_W-1:ntcb_pkg::RT_W])
                           >= a_den_reg;
        dv_next[0].r     = ntcb_pkg::DEN1_W'(a_num_reg[ntcb_pkg::NUM1_W-1:ntcb_pkg::RT_W]);
        dv_next[0].lo    = a_num_reg[ntcb_pkg::RT_W-1:0];
        dv_next[0].q     = '0;
        for (int k = 1; k <= ntcb_pkg::DIV1_STEPS; k++)
            dv_next[k] = ntcb_pkg::div1_step(dv_reg[k-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg <= '0;
        else
            dv_vld_reg <= {dv_vld_reg[ntcb_pkg::DIV1_STEPS-1:0], a_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= ntcb_pkg::DIV1_STEPS; k++)
            dv_reg[k] <= dv_next[k];
    end

    // ---------------- clamp and leading-one search ----------------
    logic [ntcb_pkg::RT_W-1:0]    rt_next;
    logic                         n1_vld_reg;
    logic [ntcb_pkg::RT_W-1:0]    n1_rt_reg;
    logic [ntcb_pkg::P_W-1:0]     n1_p_reg;
    logic [ntcb_pkg::CHAN_W-1:0]  n1_chan_reg;
    logic [ntcb_pkg::FAULT_W-1:0] n1_fault_reg;

    always_comb
    begin
        if (dv_reg[ntcb_pkg::DIV1_STEPS].sat)
            rt_next = '1;
        else if (dv_reg[ntcb_pkg::DIV1_STEPS].q == '0)
            rt_next = ntcb_pkg::RT_W'(1);
        else
            rt_next = dv_reg[ntcb_pkg::DIV1_STEPS].q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n1_vld_reg <= 1'b0;
        else
            n1_vld_reg <= dv_vld_reg[ntcb_pkg::DIV1_STEPS];
    end

    always_ff @(posedge clk)
    begin
        n1_rt_reg    <= rt_next;
        n1_p_reg     <= ntcb_pkg::msb_index(rt_next);
        n1_chan_reg  <= dv_reg[ntcb_pkg::DIV1_STEPS].chan;
        n1_fault_reg <= dv_reg[ntcb_pkg::DIV1_STEPS].fault;
    end

    // ---------------- log2 unit, one squaring a stage ----------------
    ntcb_pkg::lgc_t                 lg_reg  [0:ntcb_pkg::LOG_STEPS];
    ntcb_pkg::lgc_t                 lg_next [0:ntcb_pkg::LOG_STEPS];
    logic [ntcb_pkg::LOG_STEPS:0]   lg_vld_reg;

    always_comb
    begin
        lg_next[0].chan    = n1_chan_reg;
        lg_next[0].fault   = n1_fault_reg;
        lg_next[0].lg.p    = n1_p_reg;
        lg_next[0].lg.m    = ntcb_pkg::normalize(n1_rt_reg, n1_p_reg);
        lg_next[0].lg.frac = '0;
        for (int k = 1; k <= ntcb_pkg::LOG_STEPS; k++)
        begin
            lg_next[k].chan  = lg_reg[k-1].chan;
            lg_next[k].fault = lg_reg[k-1].fault;
            lg_next[k].lg    = ntcb_pkg::lg_step(lg_reg[k-1].lg, k - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lg_vld_reg <= '0;
        else
            lg_vld_reg <= {lg_vld_reg[ntcb_pkg::LOG_STEPS-1:0], n1_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= ntcb_pkg::LOG_STEPS; k++)
            lg_reg[k] <= lg_next[k];
    end

    // ---------------- E1: log difference, sign and magnitude ----------------
    logic [ntcb_pkg::LOG_W:0]     e1_d;
    logic                         e1_vld_reg;
    logic [ntcb_pkg::CHAN_W-1:0]  e1_chan_reg;
    logic [ntcb_pkg::FAULT_W-1:0] e1_fault_reg;
    logic                         e1_neg_reg;
    logic [ntcb_pkg::LOG_W-1:0]   e1_mag_reg;

    assign e1_d = {1'b0, lg_reg[ntcb_pkg::LOG_STEPS].lg.p, lg_reg[ntcb_pkg::LOG_STEPS].lg.frac}
                - {1'b0, rn_lg_reg[ntcb_pkg::LOG_STEPS].p, rn_lg_reg[ntcb_pkg::LOG_STEPS].frac};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_vld_reg <= 1'b0;
        else
            e1_vld_reg <= lg_vld_reg[ntcb_pkg::LOG_STEPS];
    end

    always_ff @(posedge clk)
    begin
        e1_chan_reg  <= lg_reg[ntcb_pkg::LOG_STEPS].chan;
        e1_fault_reg <= lg_reg[ntcb_pkg::LOG_STEPS].fault;
        e1_neg_reg   <= e1_d[ntcb_pkg::LOG_W];
        e1_mag_reg   <= e1_d[ntcb_pkg::LOG_W] ? ntcb_pkg::LOG_W'(~e1_d + 1'b1)
                                              : e1_d[ntcb_pkg::LOG_W-1:0];
    end

    // ---------------- E2: times ln 2, Q32 ----------------
    logic [ntcb_pkg::LOG_W+31:0]  e2_prod;
    logic                         e2_vld_reg;
    logic [ntcb_pkg::CHAN_W-1:0]  e2_chan_reg;
    logic [ntcb_pkg::FAULT_W-1:0] e2_fault_reg;
    logic                         e2_neg_reg;
    logic [ntcb_pkg::LOG_W-1:0]   e2_ln_reg;

    assign e2_prod = (ntcb_pkg::LOG_W + 32)'(e1_mag_reg)
                   * (ntcb_pkg::LOG_W + 32)'(ntcb_pkg::LN2_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e2_vld_reg <= 1'b0;
        else
            e2_vld_reg <= e1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        e2_chan_reg  <= e1_chan_reg;
        e2_fault_reg <= e1_fault_reg;
        e2_neg_reg   <= e1_neg_reg;
        e2_ln_reg    <= e2_prod[ntcb_pkg::LOG_W+31:32];
    end

    // ---------------- E3: |ln| * T2 ----------------
    logic                         e3_vld_reg;
    logic [ntcb_pkg::CHAN_W-1:0]  e3_chan_reg;
    logic [ntcb_pkg::FAULT_W-1:0] e3_fault_reg;
    logic                         e3_neg_reg;
    logic [ntcb_pkg::KT_W-1:0]    e3_lt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e3_vld_reg <= 1'b0;
        else
            e3_vld_reg <= e2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        e3_chan_reg  <= e2_chan_reg;
        e3_fault_reg <= e2_fault_reg;
        e3_neg_reg   <= e2_neg_reg;
        e3_lt_reg    <= ntcb_pkg::KT_W'(e2_ln_reg) * ntcb_pkg::KT_W'(t2_reg);
    end

    // ---------------- E4: denominator L*T2 + 100*B*2^24 ----------------
    logic [ntcb_pkg::DEN2_W-1:0]  e4_k;
    logic                         e4_vld_reg;
    logic [ntcb_pkg::CHAN_W-1:0]  e4_chan_reg;
    logic [ntcb_pkg::FAULT_W-1:0] e4_fault_reg;
    logic [ntcb_pkg::DEN2_W-1:0]  e4_den_reg;

    assign e4_k = ntcb_pkg::DEN2_W'({bk_reg, ntcb_pkg::FRAC_W'(0)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e4_vld_reg <= 1'b0;
        else
            e4_vld_reg <= e3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        e4_chan_reg  <= e3_chan_reg;
        e4_fault_reg <= e3_fault_reg;
        e4_den_reg   <= e3_neg_reg ? e4_k - ntcb_pkg::DEN2_W'(e3_lt_reg)
                                   : e4_k + ntcb_pkg::DEN2_W'(e3_lt_reg);
    end

    // ---------------- temperature divider, rounded, 17 quotient bits ----------------
    logic [ntcb_pkg::D2_W-1:0]       dpos;
    logic [ntcb_pkg::N2_W-1:0]       n2;
    ntcb_pkg::div2_t                 d2_reg  [0:ntcb_pkg::DIV2_STEPS];
    ntcb_pkg::div2_t                 d2_next [0:ntcb_pkg::DIV2_STEPS];
    logic [ntcb_pkg::DIV2_STEPS:0]   d2_vld_reg;

    always_comb
    begin
        dpos = e4_den_reg[ntcb_pkg::D2_W-1:0];
        n2   = {bt_reg, ntcb_pkg::FRAC_W'(0)} + ntcb_pkg::N2_W'(dpos >> 1);
        d2_next[0].chan  = e4_chan_reg;
        d2_next[0].fault = e4_fault_reg;
        d2_next[0].pos   = !e4_den_reg[ntcb_pkg::DEN2_W-1] && (e4_den_reg != '0);
        d2_next[0].den   = dpos;
        d2_next[0].sat   = ntcb_pkg::D2_W'(n2[ntcb_pkg::N2_W-1:ntcb_pkg::Q2_W]) >= dpos;
        d2_next[0].r     = ntcb_pkg::D2_W'(n2[ntcb_pkg::N2_W-1:ntcb_pkg::Q2_W]);
        d2_next[0].lo    = n2[ntcb_pkg::Q2_W-1:0];
        d2_next[0].q     = '0;
        for (int k = 1; k <= ntcb_pkg::DIV2_STEPS; k++)
            d2_next[k] = ntcb_pkg::div2_step(d2_reg[k-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d2_vld_reg <= '0;
        else
            d2_vld_reg <= {d2_vld_reg[ntcb_pkg::DIV2_STEPS-1:0], e4_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= ntcb_pkg::DIV2_STEPS; k++)
            d2_reg[k] <= d2_next[k];
    end

    // ---------------- output: kelvin to Celsius, saturate, faults ----------------
    ntcb_pkg::div2_t                     fin;
    logic signed [ntcb_pkg::Q2_W:0]      celsius;
    logic signed [ntcb_pkg::TEMP_W-1:0]  temp_next;

    logic                                done_reg;
    logic [ntcb_pkg::CHAN_W-1:0]         chan_out_reg;
    logic signed [ntcb_pkg::TEMP_W-1:0]  temp_out_reg;
    logic [ntcb_pkg::FAULT_W-1:0]        fault_out_reg;

    always_comb
    begin
        fin     = d2_reg[ntcb_pkg::DIV2_STEPS];
        celsius = $signed({1'b0, fin.q}) - $signed((ntcb_pkg::Q2_W + 1)'(ntcb_pkg::ZERO_C_CENTIK));
        if (fin.fault != ntcb_pkg::FAULT_OK)
            temp_next = '0;
        else if (!fin.pos || fin.sat
                 || celsius > $signed((ntcb_pkg::Q2_W + 1)'(ntcb_pkg::TEMP_MAX)))
            temp_next = ntcb_pkg::TEMP_W'(ntcb_pkg::TEMP_MAX);
        else
            temp_next = celsius[ntcb_pkg::TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d2_vld_reg[ntcb_pkg::DIV2_STEPS];
    end

    always_ff @(posedge clk)
    begin
        chan_out_reg  <= fin.chan;
        temp_out_reg  <= temp_next;
        fault_out_reg <= fin.fault;
    end

    assign done              = done_reg;
    assign result_channel    = chan_out_reg;
    assign temperature_centi = temp_out_reg;
    assign sensor_fault      = fault_out_reg;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;   // pipeline is 75 deep
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 250;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [ntcb_pkg::CODE_W-1:0]          adc_code = '0;
    logic [ntcb_pkg::CHAN_W-1:0]          sensor_channel = '0;
    logic                                 done;
    logic [ntcb_pkg::CHAN_W-1:0]          result_channel;
    logic signed [ntcb_pkg::TEMP_W-1:0]   temperature_centi;
    logic [ntcb_pkg::FAULT_W-1:0]         sensor_fault;
    logic                                 cfg_write = 1'b0;
    logic [ntcb_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [ntcb_pkg::CFG_W-1:0]           cfg_data = '0;

    ntc_beta_thermistor_converter uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .adc_code(adc_code),
        .sensor_channel(sensor_channel),
        .done(done),
        .result_channel(result_channel),
        .temperature_centi(temperature_centi),
        .sensor_fault(sensor_fault),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // one expected temperature word
    typedef struct {
        logic [ntcb_pkg::CHAN_W-1:0]        chan;
        logic signed [ntcb_pkg::TEMP_W-1:0] temp;
        logic [ntcb_pkg::FAULT_W-1:0]       fault;
    } temp_word_t;

    // directed row; has_temp marks a hand-typed expectation
    typedef struct {
        logic [ntcb_pkg::CODE_W-1:0]        code;
        logic [ntcb_pkg::CHAN_W-1:0]        chan;
        bit                                 has_temp;
        logic signed [ntcb_pkg::TEMP_W-1:0] temp;
        logic [ntcb_pkg::FAULT_W-1:0]       fault;
    } sweep_row_t;

    temp_word_t pending_temps[$];
    int         errors = 0;
    int         cycles = 0;
    bit         allow_idle = 1'b1;

    // local copy of the converter registers
    logic [ntcb_pkg::REF_W-1:0]  ref_mv = 13'd3000;
    logic [ntcb_pkg::RNOM_W-1:0] rnom_q8 = 24'd2560;
    logic [ntcb_pkg::BETA_W-1:0] beta_k = 14'd3950;
    logic [ntcb_pkg::T2_W-1:0]   t2_ck = 16'd29815;
    logic [ntcb_pkg::MASK_W-1:0] wide_mask = 5'd22;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        errors++;
    endtask

    // log2 in Q.24 by repeated squaring of a Q1.30 mantissa
    function automatic longint log2_q24(input logic [ntcb_pkg::RT_W-1:0] x);
        int          p;
        logic [63:0] m;
        logic [23:0] frac;
        p = 0;
        frac = '0;
        while (p < 31 && (x >> (p + 1)) != 0)
            p++;
        m = 64'(x) << (30 - p);
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac[23 - i] = 1'b1;
            end
        end
        return longint'((64'(p) << 24) | 64'(frac));
    endfunction

    // beta-equation temperature for one code under current registers
    function automatic temp_word_t convert_reading(input logic [ntcb_pkg::CODE_W-1:0] code,
                                                   input logic [ntcb_pkg::CHAN_W-1:0] chan);
        temp_word_t  w;
        logic [63:0] vnum, refnum, scale, rt, q;
        logic [ntcb_pkg::RT_W-1:0] rn;
        longint      d, lmag, lq, num, den, res;
        w.chan = chan;
        w.temp = '0;
        vnum = 64'(code) * ntcb_pkg::FULL_SCALE_MV;
        refnum = 64'(ref_mv) << ntcb_pkg::ADC_BITS;
        if (code == 0)
        begin
            w.fault = ntcb_pkg::FAULT_ZERO;
            return w;
        end
        if (vnum >= refnum)
        begin
            w.fault = ntcb_pkg::FAULT_HIGH;
            return w;
        end
        w.fault = ntcb_pkg::FAULT_OK;
        scale = (chan < ntcb_pkg::CHANNEL_COUNT && wide_mask[chan]) ? ntcb_pkg::WIDE_SCALE : 1;
        rt = (scale * vnum * 256) / (refnum - vnum);
        if (rt > 64'hFF_FFFF)
            rt = 64'hFF_FFFF;
        if (rt == 0)
            rt = 1;
        rn = (rnom_q8 == 0) ? 24'd1 : rnom_q8;
        d = log2_q24(ntcb_pkg::RT_W'(rt)) - log2_q24(rn);
        lmag = d < 0 ? -d : d;
        lmag = longint'((64'(lmag) * 64'(ntcb_pkg::LN2_Q32)) >> 32);
        lq = d < 0 ? -lmag : lmag;
        num = longint'(64'd100 * beta_k * t2_ck * (64'd1 << 24));
        den = lq * longint'(t2_ck) + longint'(64'd100 * beta_k * (64'd1 << 24));
        if (den <= 0)
            res = ntcb_pkg::TEMP_MAX;
        else
        begin
            q = (64'(num) + 64'(den) / 2) / 64'(den);
            if (q > 100000)
                q = 100000;
            res = longint'(q) - ntcb_pkg::ZERO_C_CENTIK;
            if (res > ntcb_pkg::TEMP_MAX)
                res = ntcb_pkg::TEMP_MAX;
        end
        w.temp = ntcb_pkg::TEMP_W'(res);
        return w;
    endfunction

    // Result checker. Outputs are sampled at the edge that ends the strobe cycle.
    always @(posedge clk)
    begin
        temp_word_t e;
        if (rst_n && done)
        begin
            if (pending_temps.size() == 0)
                report_mismatch($sformatf("unexpected word chan %0d", result_channel));
            else
            begin
                e = pending_temps.pop_front();
                if (result_channel !== e.chan)
                    report_mismatch($sformatf("chan got %0d want %0d",
                                              result_channel, e.chan));
                if (sensor_fault !== e.fault)
                    report_mismatch($sformatf("fault got %0d want %0d chan %0d",
                                              sensor_fault, e.fault, e.chan));
                if (temperature_centi !== e.temp)
                    report_mismatch($sformatf("temp got %0d want %0d chan %0d",
                                              temperature_centi, e.temp, e.chan));
            end
        end
    end

    // Watchdog: generous bound over ~2000 words with random gaps plus phase drains.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one word and hold until accepted; start stays high afterwards.
    task automatic send_word(input logic [ntcb_pkg::CODE_W-1:0] code,
                             input logic [ntcb_pkg::CHAN_W-1:0] chan,
                             input bit typed, input temp_word_t typed_word);
        start <= 1'b1;
        adc_code <= code;
        sensor_channel <= chan;
        do
            @(posedge clk);
        while (busy);
        // accepted at this edge: registers are idle-stable, predict now
        pending_temps.push_back(typed ? typed_word : convert_reading(code, chan));
    endtask

    // Random gap before the next word, when idles are allowed: drop start for a random burst.
    task automatic maybe_idle();
        if (allow_idle && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (pending_temps.size() != 0)
            @(posedge clk);
    endtask

    // Write all five registers back to back; block is idle here.
    task automatic load_registers(input logic [ntcb_pkg::REF_W-1:0] r,
                                  input logic [ntcb_pkg::RNOM_W-1:0] n,
                                  input logic [ntcb_pkg::BETA_W-1:0] b,
                                  input logic [ntcb_pkg::T2_W-1:0] t,
                                  input logic [ntcb_pkg::MASK_W-1:0] mk);
        logic [ntcb_pkg::CFG_W-1:0] vals[5];
        logic [ntcb_pkg::CFG_IDX_W-1:0] idx[5];
        vals = '{ntcb_pkg::CFG_W'(r), ntcb_pkg::CFG_W'(n), ntcb_pkg::CFG_W'(b),
                 ntcb_pkg::CFG_W'(t), ntcb_pkg::CFG_W'(mk)};
        idx = '{ntcb_pkg::CFG_REF, ntcb_pkg::CFG_RNOM, ntcb_pkg::CFG_BETA,
                ntcb_pkg::CFG_T2, ntcb_pkg::CFG_MASK};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        ref_mv = r;
        rnom_q8 = n;
        beta_k = b;
        t2_ck = t;
        wide_mask = mk;
        @(posedge clk);
    endtask

    // Random code: mostly valid readings, with edges around zero, full scale and the fault threshold.
    function automatic logic [ntcb_pkg::CODE_W-1:0] pick_code();
        int limit;
        // first faulting code
        limit = (int'(ref_mv) * 4096 + ntcb_pkg::FULL_SCALE_MV - 1) / ntcb_pkg::FULL_SCALE_MV;
        case ($urandom_range(0, 9))
            0: return ntcb_pkg::CODE_W'($urandom_range(0, 4));
            1: return ntcb_pkg::CODE_W'($urandom_range(4091, 4095));
            2: return (limit > 4095) ? ntcb_pkg::CODE_W'($urandom_range(4090, 4095))
                                     : ntcb_pkg::CODE_W'($urandom_range(
                                           limit > 3 ? limit - 3 : 0,
                                           limit + 2 > 4095 ? 4095 : limit + 2));
            3: return ntcb_pkg::CODE_W'($urandom);
            default: return ntcb_pkg::CODE_W'($urandom_range(1,
                         limit > 4096 ? 4095 : limit - 1 > 1 ? limit - 1 : 1));
        endcase
    endfunction

    sweep_row_t sweep[] = '{
        '{12'd0,    3'd0, 1'b1, 16'sd0, ntcb_pkg::FAULT_ZERO},   // zero code
        '{12'd4095, 3'd4, 1'b1, 16'sd0, ntcb_pkg::FAULT_HIGH},   // full scale above ref
        '{12'd3724, 3'd2, 1'b1, 16'sd0, ntcb_pkg::FAULT_HIGH},   // first code at ref
        '{12'd0,    3'd7, 1'b1, 16'sd0, ntcb_pkg::FAULT_ZERO},
        '{12'd3723, 3'd0, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},     // last code below ref
        '{12'd1,    3'd0, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd1,    3'd1, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd2048, 3'd0, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd2048, 3'd1, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd2048, 3'd2, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd2048, 3'd3, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd2048, 3'd4, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd2048, 3'd5, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},     // channels past the mask
        '{12'd2048, 3'd6, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd2048, 3'd7, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd1500, 3'd2, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},
        '{12'd3700, 3'd1, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK},     // huge resistance, wide
        '{12'd2730, 3'd3, 1'b0, 16'sd0, ntcb_pkg::FAULT_OK}
    };

    initial
    begin
        temp_word_t typed_word;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sweep under reset values
        foreach (sweep[i])
        begin
            typed_word = '{sweep[i].chan, sweep[i].temp, sweep[i].fault};
            send_word(sweep[i].code, sweep[i].chan, sweep[i].has_temp, typed_word);
            maybe_idle();
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_pipe();
            case (ph)
                // extremes: low ref, largest R, smallest B, largest T2, no wide channels
                0: load_registers(13'd100, 24'hFF_FFFF, 14'd500, 16'd37315, 5'd0);
                // high ref, R of zero (taken as one), largest B, all wide
                1: load_registers(13'd5000, 24'd0, 14'd10000, 16'd23315, 5'd31);
                2: load_registers(13'd3300, 24'd1, 14'd500, 16'd23315, 5'd31);
                3: load_registers(13'd3000, 24'd2560, 14'd3950, 16'd29815, 5'd22);
                default: load_registers(13'($urandom_range(100, 5000)),
                                        24'($urandom_range(1, 24'hFF_FFFF) >>
                                            $urandom_range(0, 20)),
                                        14'($urandom_range(500, 10000)),
                                        16'($urandom_range(23315, 37315)),
                                        5'($urandom_range(0, 31)));
            endcase
            allow_idle = (ph != PHASES - 1);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                send_word(pick_code(), ntcb_pkg::CHAN_W'($urandom_range(0, 9) == 0 ?
                          $urandom_range(5, 7) : $urandom_range(0, 4)), 1'b0, typed_word);
                // in phase 4, hold off once mid-phase until the pipe is empty
                if (ph == 4 && n == WORDS_PER_PHASE / 2)
                    drain_pipe();
                else
                    maybe_idle();
            end
        end

        drain_pipe();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
